// ----- sv/dual_mode_cartridge_bank_mapper_top_assert.svh -----
// ----------------------------------------------------------------------------
// dual_mode_cartridge_bank_mapper_top_assert.svh
// assertion macros shared by the bank mapper rtl
// ----------------------------------------------------------------------------
`ifndef DUAL_MODE_CARTRIDGE_BANK_MAPPER_TOP_ASSERT_SVH
`define DUAL_MODE_CARTRIDGE_BANK_MAPPER_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DMCBM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define DMCBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/dmcbm_pkg.sv -----
// ----------------------------------------------------------------------------
// dmcbm_pkg
// types and constants for the dual mode cartridge bank mapper
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dmcbm_pkg;

  localparam logic [15:0] MODE_ADDR_MASK = 16'hA131;
  localparam logic [15:0] CMD_ADDR_MASK  = 16'hE001;
  localparam logic [15:0] DIR_ADDR_MASK  = 16'hF003;
  localparam logic [7:0]  CMD_MODE       = 8'd2;
  localparam logic [7:0]  PRG_CMD_MASK   = 8'h3F;
  localparam logic [8:0]  IRQ_FORCE_LINE = 9'd128;
  localparam logic [3:0]  CHR_FIRST_PAGE = 4'hB;
  localparam logic [3:0]  CHR_LAST_PAGE  = 4'hE;

  // command mode registers
  localparam logic [15:0] CMD_BANK_SEL   = 16'h8000;
  localparam logic [15:0] CMD_BANK_DATA  = 16'h8001;
  localparam logic [15:0] CMD_MIRROR     = 16'hA000;
  localparam logic [15:0] CMD_IRQ_LATCH  = 16'hC000;
  localparam logic [15:0] CMD_IRQ_RELOAD = 16'hC001;
  localparam logic [15:0] CMD_IRQ_ACK    = 16'hE000;
  localparam logic [15:0] CMD_IRQ_EN     = 16'hE001;

  // direct mode registers
  localparam logic [15:0] DIR_PRG_LO     = 16'h8000;
  localparam logic [15:0] DIR_PRG_HI     = 16'hA000;
  localparam logic [15:0] DIR_MIRROR     = 16'h9000;

  typedef struct packed {
    logic        mode;
    logic [15:0] address;
    logic [7:0]  data;
    logic [8:0]  line;
  } in_word_t;

  typedef struct packed {
    logic [7:0] prg_bank_lo;
    logic [7:0] prg_bank_hi;
    logic [7:0] chr_bank_0;
    logic [7:0] chr_bank_1;
    logic [7:0] chr_bank_2;
    logic [7:0] chr_bank_3;
    logic [7:0] chr_bank_4;
    logic [7:0] chr_bank_5;
    logic [7:0] chr_bank_6;
    logic [7:0] chr_bank_7;
    logic       mirroring;
    logic       irq_line;
  } out_word_t;

endpackage

`default_nettype wire

// ----- sv/dual_mode_cartridge_bank_mapper_top.sv -----
// each result word is registered and appears in the cycle after its word is accepted
// throughput: one word per cycle while out_ready keeps the output draining, set by the single state update per word
// in_ready drops only while a result waits and out_ready is low
// synchronous reset clears all mapper state and the output valid
// ----------------------------------------------------------------------------
// dual_mode_cartridge_bank_mapper_top
// cartridge bank mapper with command mode and direct nibble mode,
// plus a scanline irq counter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dual_mode_cartridge_bank_mapper_top (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire dmcbm_pkg::in_word_t  in_word,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      dmcbm_pkg::out_word_t out_word
);

  import dmcbm_pkg::*;

  `include "dual_mode_cartridge_bank_mapper_top_assert.svh"

  logic [7:0] mode_byte, mode_byte_next;
  logic [7:0] prg_lo, prg_lo_next;
  logic [7:0] prg_hi, prg_hi_next;
  logic [7:0] nib_chr [8];
  logic [7:0] nib_chr_next [8];
  logic [7:0] idx_bank [8];
  logic [7:0] idx_bank_next [8];
  logic [2:0] bank_sel, bank_sel_next;
  logic       mirror_bit, mirror_bit_next;
  logic [7:0] irq_count, irq_count_next;
  logic [7:0] irq_latch, irq_latch_next;
  logic       irq_en, irq_en_next;
  logic       reload_pend, reload_pend_next;
  logic       irq_asserted, irq_asserted_next;

  logic       in_fire;
  logic       is_write;
  logic [15:0] cmd_addr;
  logic [15:0] dir_addr;
  logic [3:0]  page;
  logic [1:0]  page_off;
  logic [2:0]  slot;
  out_word_t   result;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign is_write = !in_word.mode;
  assign cmd_addr = in_word.address & CMD_ADDR_MASK;
  assign dir_addr = in_word.address & DIR_ADDR_MASK;
  assign page     = dir_addr[15:12];
  assign page_off = page[1:0] - CHR_FIRST_PAGE[1:0];
  assign slot     = {page_off, dir_addr[1]};

  always_comb begin
    mode_byte_next    = mode_byte;
    prg_lo_next       = prg_lo;
    prg_hi_next       = prg_hi;
    nib_chr_next      = nib_chr;
    idx_bank_next     = idx_bank;
    bank_sel_next     = bank_sel;
    mirror_bit_next   = mirror_bit;
    irq_count_next    = irq_count;
    irq_latch_next    = irq_latch;
    irq_en_next       = irq_en;
    reload_pend_next  = reload_pend;
    irq_asserted_next = irq_asserted;
    if (is_write) begin
      if ((in_word.address & MODE_ADDR_MASK) == MODE_ADDR_MASK) begin
        mode_byte_next = in_word.data;
      end
      if (mode_byte_next == CMD_MODE) begin
        unique case (cmd_addr)
          CMD_BANK_SEL:   bank_sel_next = in_word.data[2:0];
          CMD_BANK_DATA:  idx_bank_next[bank_sel] = in_word.data;
          CMD_MIRROR:     mirror_bit_next = in_word.data[0];
          CMD_IRQ_LATCH:  irq_latch_next = in_word.data;
          CMD_IRQ_RELOAD: reload_pend_next = 1'b1;
          CMD_IRQ_ACK: begin
            irq_asserted_next = 1'b0;
            irq_en_next       = 1'b0;
          end
          CMD_IRQ_EN:     irq_en_next = 1'b1;
          default: ;
        endcase
      end else begin
        unique case (dir_addr)
          DIR_PRG_LO: prg_lo_next = in_word.data;
          DIR_PRG_HI: prg_hi_next = in_word.data;
          DIR_MIRROR: mirror_bit_next = in_word.data[0];
          default: begin
            if (page >= CHR_FIRST_PAGE && page <= CHR_LAST_PAGE) begin
              if (!dir_addr[0]) begin
                nib_chr_next[slot] = {nib_chr[slot][7:4], in_word.data[3:0]};
              end else begin
                nib_chr_next[slot] = {in_word.data[3:0], nib_chr[slot][3:0]};
              end
            end
          end
        endcase
      end
    end else begin
      if (in_word.line == IRQ_FORCE_LINE && irq_en) begin
        irq_asserted_next = 1'b1;
      end
      if (irq_count == 8'd0 || reload_pend) begin
        irq_count_next   = irq_latch;
        reload_pend_next = 1'b0;
      end else begin
        irq_count_next = irq_count - 8'd1;
      end
      if (irq_count_next == 8'd0 && irq_en) begin
        irq_asserted_next = 1'b1;
      end
    end
  end

  always_comb begin
    if (mode_byte_next == CMD_MODE) begin
      result.prg_bank_lo = idx_bank_next[6] & PRG_CMD_MASK;
      result.prg_bank_hi = idx_bank_next[7] & PRG_CMD_MASK;
      result.chr_bank_0  = {idx_bank_next[0][7:1], 1'b0};
      result.chr_bank_1  = {idx_bank_next[0][7:1], 1'b1};
      result.chr_bank_2  = {idx_bank_next[1][7:1], 1'b0};
      result.chr_bank_3  = {idx_bank_next[1][7:1], 1'b1};
      result.chr_bank_4  = idx_bank_next[2];
      result.chr_bank_5  = idx_bank_next[3];
      result.chr_bank_6  = idx_bank_next[4];
      result.chr_bank_7  = idx_bank_next[5];
    end else begin
      result.prg_bank_lo = prg_lo_next;
      result.prg_bank_hi = prg_hi_next;
      result.chr_bank_0  = nib_chr_next[0];
      result.chr_bank_1  = nib_chr_next[1];
      result.chr_bank_2  = nib_chr_next[2];
      result.chr_bank_3  = nib_chr_next[3];
      result.chr_bank_4  = nib_chr_next[4];
      result.chr_bank_5  = nib_chr_next[5];
      result.chr_bank_6  = nib_chr_next[6];
      result.chr_bank_7  = nib_chr_next[7];
    end
    result.mirroring = !mirror_bit_next;
    result.irq_line  = irq_asserted_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_byte    <= '0;
      prg_lo       <= '0;
      prg_hi       <= '0;
      for (int i = 0; i < 8; i++) begin
        nib_chr[i]  <= '0;
        idx_bank[i] <= '0;
      end
      bank_sel     <= '0;
      mirror_bit   <= 1'b0;
      irq_count    <= '0;
      irq_latch    <= '0;
      irq_en       <= 1'b0;
      reload_pend  <= 1'b0;
      irq_asserted <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (in_fire) begin
        mode_byte    <= mode_byte_next;
        prg_lo       <= prg_lo_next;
        prg_hi       <= prg_hi_next;
        nib_chr      <= nib_chr_next;
        idx_bank     <= idx_bank_next;
        bank_sel     <= bank_sel_next;
        mirror_bit   <= mirror_bit_next;
        irq_count    <= irq_count_next;
        irq_latch    <= irq_latch_next;
        irq_en       <= irq_en_next;
        reload_pend  <= reload_pend_next;
        irq_asserted <= irq_asserted_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_word <= result;
    end
  end

  `DMCBM_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready,
    "input stalled with empty output register")
  `DMCBM_ASSERT_NEXT(a_irq_holds_idle, !in_fire, $stable(irq_asserted),
    "irq level changed without an accepted word")
  `DMCBM_ASSERT_NEXT(a_irq_out_match, in_fire, out_word.irq_line == irq_asserted,
    "result irq level differs from state")
  `DMCBM_ASSERT_NEXT(a_mirror_out_match, in_fire, out_word.mirroring == !mirror_bit,
    "result mirroring differs from state")
  `DMCBM_ASSERT_NEXT(a_cmd_prg_masked, in_fire,
    mode_byte != CMD_MODE || out_word.prg_bank_lo[7:6] == 2'b00,
    "command mode prg bank not masked")

endmodule

`default_nettype wire
